### rtl/c2s_pkg.sv
// Package for the cube-to-sphere distance core: widths, constants and payload types.
// No dependencies; the core, the divide-by-3 cell and the testbench import it.
package c2s_pkg;

    localparam int CUBE_W     = 16;
    localparam int CAM_W      = 32;
    localparam int RADIUS_W   = 31;
    localparam int DIST_W     = 32;
    localparam int SQ_W       = 31;   // square of a Q1.14 value, unsigned Q3.28
    localparam int PROD_W     = 62;   // product of two squares, Q56
    localparam int K_W        = 60;   // signed linear part of f, Q56
    localparam int F_W        = 60;   // clamped f, Q56, even width for the root chain
    localparam int DIV_W      = 64;   // dividend width of the divide-by-3 chain
    localparam int DIV_DIGIT  = 8;
    localparam int DIV_CELLS  = DIV_W / DIV_DIGIT;
    localparam int DIV3_RECIP = 683;  // ceil(2^11 / 3)
    localparam int DIV3_SHIFT = 11;
    localparam int SUM_W      = 64;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(256);
    localparam logic [15:0]         ONE_Q14    = 16'd16384;

    typedef struct packed {
        logic signed [CUBE_W-1:0] cx;
        logic signed [CUBE_W-1:0] cy;
        logic signed [CUBE_W-1:0] cz;
        logic signed [CAM_W-1:0]  camx;
        logic signed [CAM_W-1:0]  camy;
        logic signed [CAM_W-1:0]  camz;
    } side_t;

    typedef struct packed {
        logic signed [CUBE_W-1:0] x;
        logic signed [CUBE_W-1:0] y;
        logic signed [CUBE_W-1:0] z;
    } vec16_t;

endpackage

### rtl/c2s_if.sv
// Channel interfaces of the cube-to-sphere distance core: point in, result out, config.
// Depends on nothing but plain logic types.
interface c2s_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cube_x;
    logic signed [15:0] cube_y;
    logic signed [15:0] cube_z;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
    modport source (output valid, cube_x, cube_y, cube_z, camera_x, camera_y, camera_z,
                    input ready);
    modport sink (input valid, cube_x, cube_y, cube_z, camera_x, camera_y, camera_z,
                  output ready);
endinterface

interface c2s_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sphere_x;
    logic signed [15:0] sphere_y;
    logic signed [15:0] sphere_z;
    logic [31:0]        camera_distance;
    modport source (output valid, sphere_x, sphere_y, sphere_z, camera_distance,
                    input ready);
    modport sink (input valid, sphere_x, sphere_y, sphere_z, camera_distance,
                  output ready);
endinterface

interface c2s_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] planet_radius;
    modport source (output valid, planet_radius, input ready);
    modport sink (input valid, planet_radius, output ready);
endinterface

### rtl/cube_to_sphere_distance_core.sv
// Cube-to-sphere distance core: maps a cube point onto the unit sphere, scales it by
// the planet radius and measures the distance to the camera.
// It takes one point per cycle while no result waits; a waiting result stalls the whole
// pipe. Most stages are the square-root chains (30 cells per axis, 32 for the distance)
// and the 8-cell divide-by-3 chains. Reset clears all valid flags and loads planet_radius
// with 1.0; no clearing pass is needed. Depends on c2s_pkg, c2s_if.sv and the cells.
module cube_to_sphere_distance_core (
    input  logic  clk,
    input  logic  rst_n,
    c2s_point_if.sink    point,
    c2s_result_if.source result,
    c2s_cfg_if.sink      cfg
);
    import c2s_pkg::*;

    // Stage positions along the pipe
    localparam int ST_DIV0  = 3;                      // first divide cell
    localparam int ST_F     = ST_DIV0 + DIV_CELLS;    // clamped f
    localparam int F_CELLS  = F_W / 2;
    localparam int ST_PROD  = ST_F + F_CELLS + 1;     // c * root
    localparam int ST_SP    = ST_PROD + 1;            // sphere point
    localparam int ST_WORLD = ST_SP + 1;              // sphere * radius
    localparam int ST_DIFF  = ST_WORLD + 1;           // |world - camera|
    localparam int ST_SQ    = ST_DIFF + 1;
    localparam int ST_SUM   = ST_SQ + 1;
    localparam int D_CELLS  = SUM_W / 2;
    localparam int ST_OUT   = ST_SUM + D_CELLS + 1;
    localparam int FH       = F_W / 2;
    localparam int DH       = SUM_W / 2;

    logic                en;
    logic                vld_reg [ST_OUT+1];
    logic [RADIUS_W-1:0] radius_reg;

    side_t               side_reg [ST_DIFF];
    logic [SQ_W-1:0]     sq_reg   [3];
    logic [DIV_W-1:0]    p_reg    [3];
    logic signed [K_W-1:0] k_reg  [3];
    logic signed [K_W-1:0] kd_reg [DIV_CELLS][3];
    logic [F_W-1:0]      f_reg    [3];
    logic signed [46:0]  prod_reg [3];
    vec16_t              sp_line  [ST_SP:ST_OUT];
    logic signed [47:0]  wprod_reg [3];
    logic [DIST_W-1:0]   m_reg    [3];
    logic [SUM_W-1:0]    sq2_reg  [3];
    logic [SUM_W-1:0]    sum_reg;
    logic                sat_line [ST_DIFF:ST_OUT-1];
    logic [DIST_W-1:0]   dist_reg;

    // Chain wiring
    logic [DIV_W-1:0]    dv_val [3][DIV_CELLS+1];
    logic [1:0]          dv_rem [3][DIV_CELLS+1];
    logic [F_W-1:0]      fs_rad [3][F_CELLS+1];
    logic [FH:0]         fs_rem [3][F_CELLS+1];
    logic [FH-1:0]       fs_root [3][F_CELLS+1];
    logic [SUM_W-1:0]    ds_rad [D_CELLS+1];
    logic [DH:0]         ds_rem [D_CELLS+1];
    logic [DH-1:0]       ds_root [D_CELLS+1];

    // Combinational helpers
    logic signed [31:0]  sqr    [3];
    logic signed [CUBE_W-1:0] cin [3];
    logic signed [CUBE_W-1:0] cmid [3];
    logic signed [CAM_W-1:0]  cam [3];
    logic signed [K_W:0] fsum   [3];
    logic [46:0]         smag   [3];
    logic [46:0]         sq14   [3];
    logic [15:0]         smod   [3];
    logic signed [15:0]  sval   [3];
    logic signed [15:0]  spv    [3];
    logic [47:0]         wmag   [3];
    logic [47:0]         wq     [3];
    logic signed [35:0]  world  [3];
    logic signed [35:0]  dlt    [3];
    logic [35:0]         dmag   [3];
    logic                msat   [3];
    logic [SUM_W+1:0]    sum3;

    // The whole pipe advances unless a finished result is held at the output
    assign en          = !vld_reg[ST_OUT] || result.ready;
    assign point.ready = en;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ST_OUT; k++)
                vld_reg[k] <= 1'b0;
            radius_reg <= RADIUS_RST;
        end
        else
        begin
            if (en)
            begin
                vld_reg[0] <= point.valid;
                for (int k = 1; k <= ST_OUT; k++)
                    vld_reg[k] <= vld_reg[k-1];
            end
            if (cfg.valid)
                radius_reg <= cfg.planet_radius;
        end
    end

    // Axis order: x uses (y, z), y uses (z, x), z uses (x, y)
    always_comb
    begin
        cin[0] = side_reg[0].cx;
        cin[1] = side_reg[0].cy;
        cin[2] = side_reg[0].cz;
        cmid[0] = side_reg[ST_PROD-1].cx;
        cmid[1] = side_reg[ST_PROD-1].cy;
        cmid[2] = side_reg[ST_PROD-1].cz;
        cam[0] = side_reg[ST_DIFF-1].camx;
        cam[1] = side_reg[ST_DIFF-1].camy;
        cam[2] = side_reg[ST_DIFF-1].camz;
        spv[0] = sp_line[ST_SP].x;
        spv[1] = sp_line[ST_SP].y;
        spv[2] = sp_line[ST_SP].z;
        for (int a = 0; a < 3; a++)
        begin
            sqr[a]  = cin[a] * cin[a];
            fsum[a] = (K_W+1)'(kd_reg[DIV_CELLS-1][a])
                      + (K_W+1)'(signed'({1'b0, dv_val[a][DIV_CELLS][K_W-2:0]}));
            // Round to Q14 with ties away from zero, clamp to one
            smag[a] = prod_reg[a][46] ? 47'(-prod_reg[a]) : 47'(prod_reg[a]);
            sq14[a] = (smag[a] + 47'(1 << 27)) >> 28;
            smod[a] = (sq14[a] > 47'(ONE_Q14)) ? ONE_Q14 : sq14[a][15:0];
            sval[a] = prod_reg[a][46] ? -signed'(smod[a]) : signed'(smod[a]);
            // Scale to world units, round to Q8
            wmag[a] = wprod_reg[a][47] ? 48'(-wprod_reg[a]) : 48'(wprod_reg[a]);
            wq[a]   = (wmag[a] + 48'(1 << 13)) >> 14;
            world[a] = wprod_reg[a][47] ? -signed'(wq[a][35:0]) : signed'(wq[a][35:0]);
            dlt[a]  = world[a] - 36'(cam[a]);
            dmag[a] = dlt[a][35] ? 36'(-dlt[a]) : 36'(dlt[a]);
            msat[a] = |dmag[a][35:DIST_W];
        end
        sum3 = (SUM_W+2)'(sq2_reg[0]) + (SUM_W+2)'(sq2_reg[1]) + (SUM_W+2)'(sq2_reg[2]);
    end

    // Payload stages: no reset, all hold together on a stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{point.cube_x, point.cube_y, point.cube_z,
                             point.camera_x, point.camera_y, point.camera_z};
            for (int k = 1; k < ST_DIFF; k++)
                side_reg[k] <= side_reg[k-1];
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= sqr[a][SQ_W-1:0];
                // f = 1 - a^2/2 - b^2/2 + a^2*b^2/3: the last term goes down the chain
                p_reg[a]  <= DIV_W'(sq_reg[(a+1)%3]) * DIV_W'(sq_reg[(a+2)%3]);
                k_reg[a]  <= signed'(K_W'(1) << 56)
                             - signed'(K_W'(sq_reg[(a+1)%3]) << 27)
                             - signed'(K_W'(sq_reg[(a+2)%3]) << 27);
                kd_reg[0][a] <= k_reg[a];
                for (int j = 1; j < DIV_CELLS; j++)
                    kd_reg[j][a] <= kd_reg[j-1][a];
                f_reg[a]     <= fsum[a][K_W] ? '0 : F_W'(fsum[a]);
                prod_reg[a]  <= 47'(cmid[a]) * 47'(signed'({1'b0, fs_root[a][F_CELLS]}));
                wprod_reg[a] <= 48'(spv[a]) * 48'(signed'({1'b0, radius_reg}));
                m_reg[a]     <= dmag[a][DIST_W-1:0];
                sq2_reg[a]   <= SUM_W'(m_reg[a]) * SUM_W'(m_reg[a]);
            end
            sp_line[ST_SP] <= '{sval[0], sval[1], sval[2]};
            for (int k = ST_SP + 1; k <= ST_OUT; k++)
                sp_line[k] <= sp_line[k-1];
            sat_line[ST_DIFF] <= msat[0] || msat[1] || msat[2];
            sat_line[ST_SQ]   <= sat_line[ST_DIFF];
            sat_line[ST_SUM]  <= sat_line[ST_SQ] || (|sum3[SUM_W+1:SUM_W]);
            sum_reg           <= sum3[SUM_W-1:0];
            for (int k = ST_SUM + 1; k < ST_OUT; k++)
                sat_line[k] <= sat_line[k-1];
            dist_reg <= sat_line[ST_OUT-1] ? '1 : ds_root[D_CELLS];
        end
    end

    // Cell chains
    genvar ga, gj;
    generate
        for (ga = 0; ga < 3; ga++)
        begin : g_axis
            assign dv_val[ga][0] = p_reg[ga];
            assign dv_rem[ga][0] = 2'b00;
            for (gj = 0; gj < DIV_CELLS; gj++)
            begin : g_div
                c2s_div3_cell #(.IDX(gj)) u_div (
                    .clk     (clk),
                    .en      (en),
                    .val_in  (dv_val[ga][gj]),
                    .rem_in  (dv_rem[ga][gj]),
                    .val_out (dv_val[ga][gj+1]),
                    .rem_out (dv_rem[ga][gj+1])
                );
            end
            assign fs_rad[ga][0]  = f_reg[ga];
            assign fs_rem[ga][0]  = '0;
            assign fs_root[ga][0] = '0;
            for (gj = 0; gj < F_CELLS; gj++)
            begin : g_froot
                c2s_sqrt_cell #(.W(F_W), .IDX(gj)) u_sqrt (
                    .clk      (clk),
                    .en       (en),
                    .rad_in   (fs_rad[ga][gj]),
                    .rem_in   (fs_rem[ga][gj]),
                    .root_in  (fs_root[ga][gj]),
                    .rad_out  (fs_rad[ga][gj+1]),
                    .rem_out  (fs_rem[ga][gj+1]),
                    .root_out (fs_root[ga][gj+1])
                );
            end
        end
        assign ds_rad[0]  = sum_reg;
        assign ds_rem[0]  = '0;
        assign ds_root[0] = '0;
        for (gj = 0; gj < D_CELLS; gj++)
        begin : g_droot
            c2s_sqrt_cell #(.W(SUM_W), .IDX(gj)) u_sqrt (
                .clk      (clk),
                .en       (en),
                .rad_in   (ds_rad[gj]),
                .rem_in   (ds_rem[gj]),
                .root_in  (ds_root[gj]),
                .rad_out  (ds_rad[gj+1]),
                .rem_out  (ds_rem[gj+1]),
                .root_out (ds_root[gj+1])
            );
        end
    endgenerate

    assign result.valid           = vld_reg[ST_OUT];
    assign result.sphere_x        = sp_line[ST_OUT].x;
    assign result.sphere_y        = sp_line[ST_OUT].y;
    assign result.sphere_z        = sp_line[ST_OUT].z;
    assign result.camera_distance = dist_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> vld_reg[0])
        else $error("accepted point did not enter the pipe");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !point.ready)
        else $error("point taken while the output is stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.sphere_x <= 16'sd16384 && result.sphere_x >= -16'sd16384
                          && result.sphere_y <= 16'sd16384 && result.sphere_y >= -16'sd16384))
        else $error("sphere coordinate outside unit range");

endmodule

### rtl/c2s_div3_cell.sv
// One cell of the divide-by-3 chain: divides one 8-bit digit, hands on the remainder.
// Depends on c2s_pkg.
module c2s_div3_cell #(
    parameter int IDX = 0
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [c2s_pkg::DIV_W-1:0] val_in,
    input  logic [1:0]                rem_in,
    output logic [c2s_pkg::DIV_W-1:0] val_out,
    output logic [1:0]                rem_out
);
    import c2s_pkg::*;

    localparam int LSB = DIV_W - DIV_DIGIT * (IDX + 1);

    logic [DIV_W-1:0]           val_reg, val_next;
    logic [1:0]                 rem_reg, rem_next;
    logic [DIV_DIGIT+1:0]       part;
    logic [DIV_DIGIT+DIV3_SHIFT+1:0] scaled;
    logic [DIV_DIGIT-1:0]       quot;
    logic [DIV_DIGIT+1:0]       back;

    // Reciprocal multiply is exact for a partial dividend below 768
    always_comb
    begin
        part     = {rem_in, val_in[LSB +: DIV_DIGIT]};
        scaled   = (DIV_DIGIT+DIV3_SHIFT+2)'(part) * (DIV_DIGIT+DIV3_SHIFT+2)'(DIV3_RECIP);
        quot     = scaled[DIV3_SHIFT +: DIV_DIGIT];
        back     = part - (DIV_DIGIT+2)'(3) * (DIV_DIGIT+2)'(quot);
        rem_next = back[1:0];
        val_next = val_in;
        val_next[LSB +: DIV_DIGIT] = quot;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            rem_reg <= rem_next;
        end
    end

    assign val_out = val_reg;
    assign rem_out = rem_reg;

endmodule

### rtl/c2s_sqrt_cell.sv
// One cell of a restoring square-root chain: settles one root bit per cell.
// Depends on nothing outside the module; width and position come in as parameters.
module c2s_sqrt_cell #(
    parameter int W   = 64,
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   rad_in,
    input  logic [W/2:0]   rem_in,
    input  logic [W/2-1:0] root_in,
    output logic [W-1:0]   rad_out,
    output logic [W/2:0]   rem_out,
    output logic [W/2-1:0] root_out
);
    localparam int H   = W / 2;
    localparam int LSB = W - 2 - 2 * IDX;

    logic [W-1:0] rad_reg;
    logic [H:0]   rem_reg, rem_next;
    logic [H-1:0] root_reg, root_next;
    logic [H+2:0] cur, trial, diff;
    logic         fits;

    always_comb
    begin
        cur       = {rem_in, rad_in[LSB +: 2]};
        trial     = {1'b0, root_in, 2'b01};
        diff      = cur - trial;
        fits      = (cur >= trial);
        rem_next  = fits ? diff[H:0] : cur[H:0];
        root_next = {root_in[H-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

### dv/tb_top.sv
// Testbench for the cube-to-sphere distance core: random and directed points against
// a bit-accurate predictor, with random stalls on both channels and radius changes.
// Depends on c2s_pkg, the channel interfaces in c2s_if.sv and the core.
module tb_top;
    import c2s_pkg::*;

    localparam int LATENCY   = 80;
    localparam int CFG_INDEX = 0;
    localparam int LIMIT     = 400000;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic [31:0]        cam_dist;
    } sphere_res_t;

    logic clk;
    logic rst_n;

    c2s_point_if  point ();
    c2s_result_if result ();
    c2s_cfg_if    cfg ();

    cube_to_sphere_distance_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    side_t       point_q[$];
    sphere_res_t sphere_q[$];
    logic [30:0] radius;
    int          errors;
    int          cycles;
    bit          quiet_mode;   // when set, neither side idles
    bit          hold_result;  // receiver holds off for a long stretch
    int          hold_count;
    bit          send_enable;

    // Integer square root, floor.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Divide by 2^sh, rounding ties away from zero.
    function automatic longint round_away(input longint p, input int sh);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (p < 0) ? -p : p;
        q = (mag + (64'd1 << (sh - 1))) >> sh;
        return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Map one axis c, with a and b the other two coordinates.
    function automatic longint warp_axis(input longint c, input longint a, input longint b);
        longint a2;
        longint b2;
        longint f6;
        logic [63:0] f;
        longint s;
        longint r;
        a2 = a * a;
        b2 = b * b;
        f6 = (longint'(6) <<< 56) - 3 * (a2 <<< 28) - 3 * (b2 <<< 28) + 2 * a2 * b2;
        f = (f6 > 0) ? (64'(f6) / 64'd6) : 64'd0;
        s = longint'(floor_sqrt(f));
        r = round_away(c * s, 28);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r;
    endfunction

    function automatic sphere_res_t predict_sphere(input side_t p, input logic [30:0] rad);
        sphere_res_t res;
        longint sp[3];
        longint cam[3];
        longint world;
        longint d;
        logic [63:0] m;
        logic [63:0] sq;
        logic [63:0] sum;
        logic [63:0] root;
        bit sat;
        sp[0] = warp_axis(p.cx, p.cy, p.cz);
        sp[1] = warp_axis(p.cy, p.cz, p.cx);
        sp[2] = warp_axis(p.cz, p.cx, p.cy);
        cam[0] = p.camx;
        cam[1] = p.camy;
        cam[2] = p.camz;
        sum = 0;
        sat = 0;
        for (int i = 0; i < 3; i++)
        begin
            world = round_away(sp[i] * longint'({33'd0, rad}), 14);
            d = world - cam[i];
            m = (d < 0) ? -d : d;
            if (m >= (64'd1 << 32))
                sat = 1;
            else
            begin
                sq = m * m;
                if (sum + sq < sum)
                    sat = 1;
                sum = sum + sq;
            end
        end
        root = floor_sqrt(sum);
        res.sx = sp[0][15:0];
        res.sy = sp[1][15:0];
        res.sz = sp[2][15:0];
        res.cam_dist = sat ? 32'hFFFF_FFFF : root[31:0];
        return res;
    endfunction

    function automatic logic [15:0] rand_cube();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return 16'($signed($urandom_range(0, 32768)) - 16384);
        else if (k < 88)
            return (k[0]) ? 16'sd16384 : -16'sd16384;
        else
            return 16'($urandom);     // out-of-range noise, every bit toggles
    endfunction

    function automatic logic [31:0] rand_cam();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        else
            return $urandom;
    endfunction

    // Clock.
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Driver: offer the head of point_q, advance on each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        side_t sent_p;
        if (!rst_n)
        begin
            point.valid <= 0;
        end
        else
        begin
            if (point.valid && point.ready)
            begin
                sent_p = point_q.pop_front();
                sphere_q = {sphere_q, predict_sphere(sent_p, radius)};
            end
            if ((!point.valid || point.ready) )
            begin
                // Choose the next offer only once the current one has gone.
                if (send_enable && point_q.size() > (point.valid && point.ready ? 0 : 0)
                    && (quiet_mode || $urandom_range(0, 99) >= 9))
                begin
                    if (point.valid && point.ready && point_q.size() == 0)
                        point.valid <= 0;
                    else
                    begin
                        point.valid    <= 1;
                        point.cube_x   <= point_q[0].cx;
                        point.cube_y   <= point_q[0].cy;
                        point.cube_z   <= point_q[0].cz;
                        point.camera_x <= point_q[0].camx;
                        point.camera_y <= point_q[0].camy;
                        point.camera_z <= point_q[0].camz;
                    end
                end
                else
                    point.valid <= 0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        sphere_res_t exp_r;
        if (!rst_n)
        begin
            result.ready <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (sphere_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d dist=%0d", $time,
                             result.sphere_x, result.sphere_y, result.sphere_z,
                             result.camera_distance);
                end
                else
                begin
                    exp_r = sphere_q.pop_front();
                    if (result.sphere_x !== exp_r.sx)
                    begin
                        errors++;
                        $display("%0t: sphere_x expected %0d actual %0d", $time,
                                 exp_r.sx, result.sphere_x);
                    end
                    if (result.sphere_y !== exp_r.sy)
                    begin
                        errors++;
                        $display("%0t: sphere_y expected %0d actual %0d", $time,
                                 exp_r.sy, result.sphere_y);
                    end
                    if (result.sphere_z !== exp_r.sz)
                    begin
                        errors++;
                        $display("%0t: sphere_z expected %0d actual %0d", $time,
                                 exp_r.sz, result.sphere_z);
                    end
                    if (result.camera_distance !== exp_r.cam_dist)
                    begin
                        errors++;
                        $display("%0t: camera_distance expected %0h actual %0h", $time,
                                 exp_r.cam_dist, result.camera_distance);
                    end
                end
            end
            // Hold off in its own count, otherwise drop ready at random with a chance of 9 in 100.
            if (hold_count > 0)
            begin
                hold_count <= hold_count - 1;
                result.ready <= 0;
            end
            else if (hold_result)
            begin
                hold_count <= 400;
                result.ready <= 0;
            end
            else
                result.ready <= quiet_mode || $urandom_range(0, 99) >= 9;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_radius(input logic [30:0] val);
        @(posedge clk);
        cfg.valid         <= 1;
        cfg.planet_radius <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        radius = val;
        cfg.valid <= 0;
    endtask

    task automatic drain();
        while (point_q.size() != 0 || point.valid || sphere_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic add_point(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [31:0] cx,
                             input logic [31:0] cy, input logic [31:0] cz);
        side_t p;
        p = '{x, y, z, cx, cy, cz};
        point_q = {point_q, p};
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
            add_point(rand_cube(), rand_cube(), rand_cube(), rand_cam(), rand_cam(),
                      rand_cam());
    endtask

    initial
    begin
        logic [30:0] radii[5];
        radii = '{31'd256, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'h0000_6400};
        errors = 0;
        cycles = 0;
        quiet_mode = 0;
        hold_result = 0;
        hold_count = 0;
        send_enable = 1;
        radius = RADIUS_RST;
        rst_n = 0;
        point.valid = 0;
        point.cube_x = 0;
        point.cube_y = 0;
        point.cube_z = 0;
        point.camera_x = 0;
        point.camera_y = 0;
        point.camera_z = 0;
        result.ready = 0;
        cfg.valid = 0;
        cfg.planet_radius = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // Directed: corners, faces, center, out of range and distance saturation.
        add_point(16'sd16384, 0, 0, 0, 0, 0);
        add_point(-16'sd16384, 0, 0, 0, 0, 0);
        add_point(16'sd16384, 16'sd16384, 16'sd16384, 0, 0, 0);
        add_point(-16'sd16384, -16'sd16384, -16'sd16384, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_point(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_point(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1, 32'h5555_5555);
        add_point(16'h8000, 16'h8000, 16'h8000, 32'hAAAA_AAAA, 0, 0);
        add_point(16'sd8192, -16'sd8192, 16'sd16384, 100, -100, 256);
        add_point(16'h7FFF, 0, 0, 0, 0, 0);
        add_point(16'sd16383, 16'sd1, -16'sd1, 0, 0, 0);
        drain();

        // One phase per radius setting; the extremes included.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_radius(radii[ph]);
            add_point(16'sd16384, 16'sd16384, 16'sd16384, 32'h7FFF_FFFF, 0, 32'h8000_0000);
            add_point(-16'sd16384, 16'sd0, 16'sd16384, 0, 0, 0);
            if (ph == 1)
                quiet_mode = 1;      // long stretch with no idling
            add_random(210);
            if (ph == 2)
            begin
                // Long hold-off on the result side while points keep coming.
                @(posedge clk);
                hold_result <= 1;
                @(posedge clk);
                hold_result <= 0;
            end
            drain();                 // sender pauses until every result has come
            quiet_mode = 0;
        end
        write_radius(31'($urandom));

        add_random(40);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### cube_to_sphere_distance_core.f
rtl/c2s_pkg.sv
rtl/c2s_if.sv
rtl/c2s_div3_cell.sv
rtl/c2s_sqrt_cell.sv
rtl/cube_to_sphere_distance_core.sv
dv/tb_top.sv
